[design/pvc_pkg.sv]
`default_nettype none
package pvc_pkg;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NONCANON  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   // longest encoding: a zero marker byte plus eight raw bytes
   localparam logic [3:0] MAX_LEN = 4'd9;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic [3:0] code_length;
   } enc_byte_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  code_length;
      logic [63:0] value;
      logic [1:0]  status;
   } dec_result_type;

   function automatic logic [63:0] zz_map(input logic [63:0] v);
      zz_map = {v[62:0], 1'b0} ^ {64{v[63]}};
   endfunction

   function automatic logic [63:0] zz_unmap(input logic [63:0] u);
      zz_unmap = {1'b0, u[63:1]} ^ {64{u[0]}};
   endfunction

endpackage
`default_nettype wire

[design/prefix_varint64_codec_top.sv]
`default_nettype none
// Channel   Direction  Fields
// req_      in         operation, value, data_byte, signed_mode, buffer_end
// rsp_      out        kind, out_byte, last_byte, code_length, decoded_value, status
//
// A decode word waits in the input register until the output register can take it and yields zero or one rsp word.
// An encode word of length L (1..9) stays in the input register until all L bytes are emitted,
// one encoded byte per cycle while the output register can take it, the byte counter there picking each byte.
// One output register parts the channels; req_ready falls only while an encode
// is still emitting or the output register is full and not taken.
// Synchronous active-high reset clears valid flags and the decode run state.
module prefix_varint64_codec_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [63:0] req_value,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_signed_mode,
   input  wire logic        req_buffer_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte,
   output logic [3:0]       rsp_code_length,
   output logic [63:0]      rsp_decoded_value,
   output logic [1:0]       rsp_status
);
   import pvc_pkg::*;

   logic        in_valid_ff;
   logic        op_ff;
   logic [63:0] value_ff;
   logic [7:0]  byte_ff;
   logic        sgn_ff;
   logic        bend_ff;
   logic [3:0]  idx_ff;

   logic        out_valid_ff;
   logic        kind_ff;
   logic [7:0]  out_byte_ff;
   logic        last_ff;
   logic [3:0]  len_ff;
   logic [63:0] dec_value_ff;
   logic [1:0]  status_ff;

   enc_byte_type   enc;
   dec_result_type dec;

   logic advance;
   logic in_done;
   logic load;

   pvc_encode u_encode (
      .value       (value_ff),
      .signed_mode (sgn_ff),
      .index       (idx_ff),
      .enc         (enc)
   );

   pvc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (advance && (op_ff == OP_DECODE)),
      .data_byte   (byte_ff),
      .signed_mode (sgn_ff),
      .buffer_end  (bend_ff),
      .result      (dec)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign in_done   = advance && ((op_ff == OP_DECODE) || enc.last_byte);
   assign req_ready = !in_valid_ff || in_done;
   assign load      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idx_ff      <= 4'd0;
      end else if (load) begin
         in_valid_ff <= 1'b1;
         idx_ff      <= 4'd0;
      end else if (in_done) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         idx_ff <= idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         byte_ff  <= req_data_byte;
         sgn_ff   <= req_signed_mode;
         bend_ff  <= req_buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= (op_ff == OP_ENCODE) || dec.valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (op_ff == OP_ENCODE) begin
            kind_ff      <= KIND_BYTE;
            out_byte_ff  <= enc.out_byte;
            last_ff      <= enc.last_byte;
            len_ff       <= enc.code_length;
            dec_value_ff <= 64'd0;
            status_ff    <= STATUS_OK;
         end else begin
            kind_ff      <= KIND_VALUE;
            out_byte_ff  <= 8'd0;
            last_ff      <= 1'b0;
            len_ff       <= dec.code_length;
            dec_value_ff <= dec.value;
            status_ff    <= dec.status;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_last_byte     = last_ff;
   assign rsp_code_length   = len_ff;
   assign rsp_decoded_value = dec_value_ff;
   assign rsp_status        = status_ff;

endmodule
`default_nettype wire

[design/pvc_encode.sv]
`default_nettype none
module pvc_encode (
   input  wire logic [63:0]           value,
   input  wire logic                  signed_mode,
   input  wire logic [3:0]            index,
   output pvc_pkg::enc_byte_type      enc
);
   import pvc_pkg::*;

   logic [63:0] v;
   logic [3:0]  len;
   logic [64:0] enc_wide;
   logic [71:0] word;
   logic [71:0] shifted;

   assign v = signed_mode ? zz_map(value) : value;

   // shortest length whose 7*len payload bits hold v; otherwise the 9-byte form
   always_comb begin
      len = MAX_LEN;
      for (int l = 8; l >= 1; l--) begin
         if ((v >> (7 * l)) == 64'd0) len = 4'(l);
      end
   end

   always_comb begin
      enc_wide = {v, 1'b1} << (len - 4'd1);
      if (len == MAX_LEN) word = {v, 8'h00};
      else word = {8'h00, enc_wide[63:0]};
   end

   assign shifted         = word >> {index, 3'b000};
   assign enc.out_byte    = shifted[7:0];
   assign enc.last_byte   = (index == len - 4'd1);
   assign enc.code_length = len;

endmodule
`default_nettype wire

[design/pvc_decode.sv]
`default_nettype none
module pvc_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  signed_mode,
   input  wire logic                  buffer_end,
   output pvc_pkg::dec_result_type    result
);
   import pvc_pkg::*;

   logic [3:0]  exp_len_ff, exp_len_in;
   logic [3:0]  seen_ff, seen_in;
   logic [63:0] payload_ff, payload_in;
   logic        run_signed_ff, run_signed_in;

   logic [3:0]  first_len;
   logic [2:0]  lane;
   logic        lane_en;
   logic        complete;
   logic [63:0] res;
   logic        undersized;

   // run length from the first byte: trailing zeros plus one, zero byte means 9
   always_comb begin
      first_len = MAX_LEN;
      for (int i = 7; i >= 0; i--) begin
         if (data_byte[i]) first_len = 4'(i + 1);
      end
   end

   always_comb begin
      lane    = 3'd0;
      lane_en = 1'b0;
      if (exp_len_ff == 4'd0) begin
         exp_len_in    = first_len;
         seen_in       = 4'd1;
         run_signed_in = signed_mode;
         payload_in    = (first_len == MAX_LEN) ? 64'd0 : {56'd0, data_byte};
      end else begin
         exp_len_in    = exp_len_ff;
         seen_in       = seen_ff + 4'd1;
         run_signed_in = run_signed_ff;
         // 9-byte form skips the zero marker byte
         if (exp_len_ff == MAX_LEN) begin
            lane    = 3'(seen_ff - 4'd1);
            lane_en = (seen_ff >= 4'd1) && (seen_ff <= 4'd8);
         end else begin
            lane    = seen_ff[2:0];
            lane_en = (seen_ff < 4'd8);
         end
         payload_in = payload_ff;
         if (lane_en) payload_in = payload_ff | ({56'd0, data_byte} << {lane, 3'b000});
      end
   end

   assign complete = (seen_in >= exp_len_in);
   assign res = (exp_len_in == MAX_LEN) ? payload_in : (payload_in >> exp_len_in);

   // canonical only if the value needs the full length
   always_comb begin
      case (exp_len_in)
         4'd2:    undersized = (res[63:7]  == '0);
         4'd3:    undersized = (res[63:14] == '0);
         4'd4:    undersized = (res[63:21] == '0);
         4'd5:    undersized = (res[63:28] == '0);
         4'd6:    undersized = (res[63:35] == '0);
         4'd7:    undersized = (res[63:42] == '0);
         4'd8:    undersized = (res[63:49] == '0);
         4'd9:    undersized = (res[63:56] == '0);
         default: undersized = 1'b0;
      endcase
   end

   always_comb begin
      result.valid       = step && (complete || buffer_end);
      result.code_length = exp_len_in;
      if (!complete) begin
         result.value  = 64'd0;
         result.status = STATUS_TRUNCATED;
      end else if (undersized) begin
         result.value  = 64'd0;
         result.status = STATUS_NONCANON;
      end else begin
         result.value  = run_signed_in ? zz_unmap(res) : res;
         result.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff    <= 4'd0;
         seen_ff       <= 4'd0;
         payload_ff    <= 64'd0;
         run_signed_ff <= 1'b0;
      end else if (step) begin
         if (complete || buffer_end) begin
            exp_len_ff    <= 4'd0;
            seen_ff       <= 4'd0;
            payload_ff    <= 64'd0;
            run_signed_ff <= 1'b0;
         end else begin
            exp_len_ff    <= exp_len_in;
            seen_ff       <= seen_in;
            payload_ff    <= payload_in;
            run_signed_ff <= run_signed_in;
         end
      end
   end

endmodule
`default_nettype wire
